@@ hdl/scfl_pkg.sv @@
package scfl_pkg;

	localparam int CLASS_W      = 3;
	localparam int SLOT_W       = 10;
	localparam int COUNT_W      = 7;
	localparam int RESULT_LIMIT = 64;

	typedef enum logic [1:0] {
		CMD_PUSH       = 2'd0,
		CMD_POP        = 2'd1,
		CMD_PUSH_CHAIN = 2'd2,
		CMD_POP_BATCH  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_POP_WAIT,
		ST_PUSH_WALK,
		ST_EMPTY
	} state_t;

endpackage

@@ hdl/size_class_free_list_manager_core.sv @@
// Segregated size-class free list manager.
// Input channel (in_valid/in_stall) takes one command item: push one slot, pop one
// slot, push a chain of count slots, or pop up to count slots from a size class.
// Output channel (out_valid/out_stall) gives got_slot/out_slot/last items: one for
// a pop, up to count for a batch pop, none for pushes. last marks the final item.
// Class heads sit in flops; slot successors sit in a link RAM with a registered
// synchronous read. Only one command is in flight at a time.
// Sequence: a push is written from the dispatch state; a pop reads the head's link
// in the dispatch state and puts its item in the output register from the pop-wait
// state; a batch pop gives one item per cycle while the output is not stalled, each
// link read giving the next slot; a push chain does one link read per cycle to its tail.
// The next command is accepted once the last item is in the output register.
// A stalled output register holds its item and the batch pop link walk waits on it.
// Reset empties every class; the link RAM is not cleared, so no sweep is needed
// and items are accepted from the first cycle after reset.
module size_class_free_list_manager_core
	import scfl_pkg::*;
#(
	parameter int NUM_CLASSES = 8,
	parameter int NUM_SLOTS   = 1024,
	parameter int MAX_BATCH   = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [CLASS_W-1:0] class_sel,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [COUNT_W-1:0] count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               got_slot,
	output logic [SLOT_W-1:0]  out_slot,
	output logic               last
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int LIM   = (MAX_BATCH < RESULT_LIMIT) ? MAX_BATCH : RESULT_LIMIT;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} link_t;

	state_t state_q, state_d;

	link_t link_mem [NUM_SLOTS];
	link_t rdata_s1;
	link_t head_q [NUM_CLASSES];

	cmd_t               cmd_q;
	logic [CLS_W-1:0]   cls_q;
	logic               cls_ok_q;
	logic [IDX_W-1:0]   slot_q;
	logic               slot_ok_q;
	logic [COUNT_W-1:0] n_q;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0]   cur_q, cur_d;

	logic               out_valid_q, got_slot_q, last_q;
	logic [SLOT_W-1:0]  out_slot_q;

	logic [CLS_W+CLASS_W-1:0] cls_wide;
	logic [IDX_W+SLOT_W-1:0]  slot_wide;
	logic [IDX_W+SLOT_W-1:0]  cur_wide;
	logic [COUNT_W-1:0]       n_clamp, n_in;

	logic             accept, out_free;
	logic             rd_en, mem_we, hd_we;
	logic [IDX_W-1:0] rd_addr, mem_waddr;
	link_t            mem_wdata, hd_wdata, hd_cur;
	logic             emit, emit_got, emit_last;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign cls_wide  = {{CLS_W{1'b0}}, class_sel};
	assign slot_wide = {{IDX_W{1'b0}}, slot};
	assign cur_wide  = {{SLOT_W{1'b0}}, cur_q};
	assign hd_cur    = head_q[cls_q];
	assign n_clamp   = (count > COUNT_W'(LIM)) ? COUNT_W'(LIM) : count;

	always_comb begin
		unique case (cmd_t'(cmd))
			CMD_PUSH, CMD_POP: n_in = COUNT_W'(1);
			CMD_PUSH_CHAIN:    n_in = (n_clamp == '0) ? COUNT_W'(1) : n_clamp;
			default:           n_in = n_clamp;
		endcase
	end

	// command register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(cmd);
			cls_q     <= cls_wide[CLS_W-1:0];
			cls_ok_q  <= (cls_wide < (CLS_W+CLASS_W)'(NUM_CLASSES));
			slot_q    <= slot_wide[IDX_W-1:0];
			slot_ok_q <= (slot_wide < (IDX_W+SLOT_W)'(NUM_SLOTS));
			n_q       <= n_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cur_d     = cur_q;
		rd_en     = 1'b0;
		rd_addr   = cur_q;
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = hd_cur;
		hd_we     = 1'b0;
		hd_wdata  = '{vld: 1'b1, idx: slot_q};
		emit      = 1'b0;
		emit_got  = 1'b0;
		emit_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_IDLE;
				unique case (cmd_q)
					CMD_PUSH, CMD_PUSH_CHAIN: begin
						if (cls_ok_q && slot_ok_q) begin
							if (n_q > COUNT_W'(1)) begin
								// walk from the chain head to find its tail
								rd_en   = 1'b1;
								rd_addr = slot_q;
								cur_d   = slot_q;
								cnt_d   = '0;
								state_d = ST_PUSH_WALK;
							end else begin
								mem_we = 1'b1;
								hd_we  = 1'b1;
							end
						end
					end
					default: begin
						if (!cls_ok_q || n_q == '0 || !hd_cur.vld) begin
							state_d = ST_EMPTY;
						end else begin
							rd_en   = 1'b1;
							rd_addr = hd_cur.idx;
							cur_d   = hd_cur.idx;
							cnt_d   = '0;
							state_d = ST_POP_WAIT;
						end
					end
				endcase
			end
			ST_POP_WAIT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_got  = 1'b1;
					emit_last = (cnt_q + COUNT_W'(1) == n_q) || !rdata_s1.vld;
					hd_we     = 1'b1;
					hd_wdata  = rdata_s1;
					if (emit_last) begin
						// earlier links of the batch already point forward; only the tail
						// needs a null link
						mem_we    = (cmd_q == CMD_POP_BATCH);
						mem_waddr = cur_q;
						mem_wdata = '0;
						state_d   = ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = rdata_s1.idx;
						cur_d   = rdata_s1.idx;
						cnt_d   = cnt_q + COUNT_W'(1);
					end
				end
			end
			ST_PUSH_WALK: begin
				if (!rdata_s1.vld || cnt_q + COUNT_W'(2) == n_q) begin
					mem_we    = 1'b1;
					mem_waddr = rdata_s1.vld ? rdata_s1.idx : cur_q;
					hd_we     = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rdata_s1.idx;
					cur_d   = rdata_s1.idx;
					cnt_d   = cnt_q + COUNT_W'(1);
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		cur_q <= cur_d;
	end

	// link RAM, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i] <= '0;
			end
		end else if (hd_we) begin
			head_q[cls_q] <= hd_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			got_slot_q <= emit_got;
			out_slot_q <= emit_got ? cur_wide[SLOT_W-1:0] : '0;
			last_q     <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign got_slot  = got_slot_q;
	assign out_slot  = out_slot_q;
	assign last      = last_q;

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DISPATCH)
		else $error("accepted item not dispatched");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !got_slot |-> last && out_slot == '0)
		else $error("empty result without last or with nonzero slot");

	a_ram_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("link RAM read and write in the same cycle");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP_WAIT |-> cnt_q < n_q)
		else $error("batch pop ran past its count");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !out_valid_q || !out_stall)
		else $error("result written over a stalled item");

endmodule
